// ===== rtl/mrd_pkg.sv =====
// Shared types and constants of the MQTT receive deframer.
package mrd_pkg;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] value;
      logic [3:0]  packet_type;
      logic        last;
   } rsp_type;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [2:0] KIND_TOPIC  = 3'd0;
   localparam logic [2:0] KIND_MSG    = 3'd1;
   localparam logic [2:0] KIND_PUBACK = 3'd2;
   localparam logic [2:0] KIND_CTRL   = 3'd3;
   localparam logic [2:0] KIND_PING   = 3'd4;
   localparam logic [2:0] KIND_FRAME  = 3'd5;
   localparam logic [2:0] KIND_DROP   = 3'd6;

   localparam logic [3:0] TYPE_CONNACK = 4'd2;
   localparam logic [3:0] TYPE_PUBLISH = 4'd3;
   localparam logic [3:0] TYPE_PINGREQ = 4'd12;

   localparam logic CSR_PAYLOAD_LIMIT = 1'b0;
   localparam logic CSR_KEEPALIVE     = 1'b1;

   localparam int LEN_WIDTH          = 28;
   localparam int IDLE_WIDTH         = 27;
   localparam int THR_WIDTH          = 26;
   localparam int PING_MS_PER_SECOND = 1000 * 3 / 4;
   localparam logic [LEN_WIDTH-1:0] PAYLOAD_LIMIT_RESET = 28'd4096;
   localparam logic [THR_WIDTH-1:0] PING_THR_RESET      = 26'(60 * PING_MS_PER_SECOND);

endpackage

// ===== rtl/mrd_core.sv =====
// Packet parser and keepalive timer state, one item per step.
module mrd_core #(
   parameter int TOPIC_LIMIT = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  mrd_pkg::req_type                 item,
   input  logic [mrd_pkg::LEN_WIDTH-1:0]    payload_limit,
   input  logic [mrd_pkg::THR_WIDTH-1:0]    ping_thr,
   output logic                             res_valid,
   output mrd_pkg::rsp_type                 res,
   output logic                             stopped
);
   import mrd_pkg::*;

   localparam logic [15:0] TopicCap = 16'(TOPIC_LIMIT - 1);

   localparam logic [3:0] PH_HEADER  = 4'd0;
   localparam logic [3:0] PH_LENGTH  = 4'd1;
   localparam logic [3:0] PH_BODY    = 4'd2;
   localparam logic [3:0] PH_DISCARD = 4'd3;
   localparam logic [3:0] PH_TLEN_HI = 4'd4;
   localparam logic [3:0] PH_TLEN_LO = 4'd5;
   localparam logic [3:0] PH_TOPIC   = 4'd6;
   localparam logic [3:0] PH_ID_HI   = 4'd7;
   localparam logic [3:0] PH_ID_LO   = 4'd8;
   localparam logic [3:0] PH_MESSAGE = 4'd9;
   localparam logic [3:0] PH_SKIP    = 4'd10;

   logic [3:0]            phase_ff, phase_in;
   logic [3:0]            type_ff, type_in;
   logic [3:0]            flag_ff, flag_in;
   logic [LEN_WIDTH-1:0]  accum_ff, accum_in;
   logic [2:0]            lcount_ff, lcount_in;
   logic [LEN_WIDTH-1:0]  left_ff, left_in;
   logic [15:0]           tlen_ff, tlen_in;
   logic [15:0]           tseen_ff, tseen_in;
   logic                  pub_ok_ff, pub_ok_in;
   logic [7:0]            id_high_ff, id_high_in;
   logic [7:0]            connack_ff, connack_in;
   logic [IDLE_WIDTH-1:0] idle_ff, idle_in;
   logic                  any_seen_ff, any_seen_in;
   logic                  stopped_ff, stopped_in;

   logic [7:0]            b;
   logic [1:0]            qos;
   logic                  is_pub;
   logic [LEN_WIDTH-1:0]  accum_next;
   logic [4:0]            shamt;
   logic [16:0]           need;
   logic [15:0]           keep;
   logic [15:0]           tseen_next;
   logic [IDLE_WIDTH-1:0] idle_inc;
   logic [LEN_WIDTH-1:0]  left_next;
   logic                  tail;
   logic                  finish;

   assign b      = item.rx_byte;
   assign qos    = flag_ff[2:1];
   assign is_pub = (type_ff == TYPE_PUBLISH);
   assign shamt  = 5'(lcount_ff[1:0]) * 5'd7;
   assign accum_next = accum_ff + (LEN_WIDTH'(b[6:0]) << shamt);
   assign need   = 17'd2 + 17'(tlen_ff[15:8]) * 17'd256 + 17'(b) + ((qos != 2'd0) ? 17'd2 : 17'd0);
   assign keep   = (tlen_ff < TopicCap) ? tlen_ff : TopicCap;
   assign tseen_next = tseen_ff + 16'd1;
   assign idle_inc = (idle_ff != {IDLE_WIDTH{1'b1}}) ? idle_ff + 1'b1 : idle_ff;
   assign left_next = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

   always_comb begin
      phase_in    = phase_ff;
      type_in     = type_ff;
      flag_in     = flag_ff;
      accum_in    = accum_ff;
      lcount_in   = lcount_ff;
      left_in     = left_ff;
      tlen_in     = tlen_ff;
      tseen_in    = tseen_ff;
      pub_ok_in   = pub_ok_ff;
      id_high_in  = id_high_ff;
      connack_in  = connack_ff;
      idle_in     = idle_ff;
      any_seen_in = any_seen_ff;
      stopped_in  = stopped_ff;
      res_valid   = 1'b0;
      res.kind    = KIND_TOPIC;
      res.value   = 16'd0;
      res.packet_type = type_ff;
      res.last    = 1'b0;
      tail        = 1'b0;
      finish      = 1'b0;
      if (!stopped_ff) begin
         if (item.operation == OP_TICK) begin
            idle_in = idle_inc;
            if (ping_thr != '0 && any_seen_ff && idle_inc > IDLE_WIDTH'(ping_thr)) begin
               idle_in = '0;
               res_valid = 1'b1;
               res.kind = KIND_PING;
               res.packet_type = TYPE_PINGREQ;
            end
         end else begin
            unique case (phase_ff)
               PH_LENGTH: begin
                  accum_in  = accum_next;
                  lcount_in = lcount_ff + 3'd1;
                  if (b[7]) begin
                     if (lcount_ff + 3'd1 >= 3'd4) begin
                        stopped_in = 1'b1;
                        res_valid  = 1'b1;
                        res.kind   = KIND_FRAME;
                     end
                  end else begin
                     left_in = accum_next;
                     if (accum_next > payload_limit) begin
                        phase_in  = PH_DISCARD;
                        res_valid = 1'b1;
                        res.kind  = KIND_DROP;
                     end else if (accum_next == '0) begin
                        finish = 1'b1;
                        if (!is_pub) begin
                           res_valid = 1'b1;
                           res.kind  = KIND_CTRL;
                           res.value = (type_ff == TYPE_CONNACK) ? 16'(connack_ff) : 16'd0;
                        end
                     end else begin
                        phase_in = is_pub ? PH_TLEN_HI : PH_BODY;
                     end
                  end
               end
               PH_BODY: begin
                  if (accum_ff - left_ff == LEN_WIDTH'(1) && type_ff == TYPE_CONNACK) begin
                     connack_in = b;
                  end
                  left_in = left_ff - 1'b1;
                  if (left_ff == LEN_WIDTH'(1)) begin
                     finish    = 1'b1;
                     res_valid = 1'b1;
                     res.kind  = KIND_CTRL;
                     res.value = (type_ff == TYPE_CONNACK) ? 16'(connack_in) : 16'd0;
                  end
               end
               PH_DISCARD, PH_SKIP: begin
                  tail = 1'b1;
               end
               PH_TLEN_HI: begin
                  tlen_in  = {b, 8'h00};
                  phase_in = PH_TLEN_LO;
                  tail     = 1'b1;
               end
               PH_TLEN_LO: begin
                  tlen_in   = {tlen_ff[15:8], b};
                  tseen_in  = 16'd0;
                  pub_ok_in = accum_ff > LEN_WIDTH'(need);
                  if (LEN_WIDTH'(need) > accum_ff) begin
                     phase_in = PH_SKIP;
                  end else if ({tlen_ff[15:8], b} != 16'd0) begin
                     phase_in = PH_TOPIC;
                  end else begin
                     phase_in = (qos != 2'd0) ? PH_ID_HI : PH_MESSAGE;
                  end
                  tail = 1'b1;
               end
               PH_TOPIC: begin
                  if (pub_ok_ff && tseen_ff < keep) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_TOPIC;
                     res.value = 16'(b);
                     res.last  = (tseen_next == keep);
                  end
                  tseen_in = tseen_next;
                  if (tseen_next == tlen_ff) begin
                     phase_in = (qos != 2'd0) ? PH_ID_HI : PH_MESSAGE;
                  end
                  tail = 1'b1;
               end
               PH_ID_HI: begin
                  id_high_in = b;
                  phase_in   = PH_ID_LO;
                  tail       = 1'b1;
               end
               PH_ID_LO: begin
                  if (qos == 2'd1) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_PUBACK;
                     res.value = {id_high_ff, b};
                  end
                  phase_in = PH_MESSAGE;
                  tail     = 1'b1;
               end
               PH_MESSAGE: begin
                  if (pub_ok_ff) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_MSG;
                     res.value = 16'(b);
                     res.last  = (left_ff == LEN_WIDTH'(1));
                  end
                  tail = 1'b1;
               end
               default: begin
                  type_in    = b[7:4];
                  flag_in    = b[3:0];
                  accum_in   = '0;
                  lcount_in  = 3'd0;
                  connack_in = 8'hFF;
                  pub_ok_in  = 1'b0;
                  phase_in   = PH_LENGTH;
               end
            endcase
            if (tail) begin
               left_in = left_next;
               if (left_next == '0) begin
                  finish = 1'b1;
               end
            end
            if (finish) begin
               phase_in    = PH_HEADER;
               idle_in     = '0;
               any_seen_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         type_ff     <= 4'd0;
         flag_ff     <= 4'd0;
         accum_ff    <= '0;
         lcount_ff   <= 3'd0;
         left_ff     <= '0;
         tlen_ff     <= 16'd0;
         tseen_ff    <= 16'd0;
         pub_ok_ff   <= 1'b0;
         id_high_ff  <= 8'd0;
         connack_ff  <= 8'hFF;
         idle_ff     <= '0;
         any_seen_ff <= 1'b0;
         stopped_ff  <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         type_ff     <= type_in;
         flag_ff     <= flag_in;
         accum_ff    <= accum_in;
         lcount_ff   <= lcount_in;
         left_ff     <= left_in;
         tlen_ff     <= tlen_in;
         tseen_ff    <= tseen_in;
         pub_ok_ff   <= pub_ok_in;
         id_high_ff  <= id_high_in;
         connack_ff  <= connack_in;
         idle_ff     <= idle_in;
         any_seen_ff <= any_seen_in;
         stopped_ff  <= stopped_in;
      end
   end

   assign stopped = stopped_ff;

endmodule

// ===== rtl/mqtt_receive_deframer_unit.sv =====
// MQTT receive deframer top level: input register, parser step, result register, CSRs.
//
//  Channel  Direction  Handshake           Payload
//  req      in         req_valid/req_stall  req_data  (operation, rx_byte)
//  rsp      out        rsp_valid/rsp_stall  rsp_data  (kind, value, packet_type, last)
//  csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One item per cycle while rsp is not stalled: an accepted item sits in the input
// register and is parsed straight into the result register once that can take it;
// the parser state update is the loop.
// Reset (synchronous, active high) clears the parser, timer and both valid flags.
// A stalled result holds the input register, which then stalls req.
module mqtt_receive_deframer_unit #(
   parameter int TOPIC_LIMIT = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mrd_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mrd_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [mrd_pkg::LEN_WIDTH-1:0] csr_data
);
   import mrd_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   req_type              in_data_ff;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_data_ff;
   logic [LEN_WIDTH-1:0] limit_ff;
   logic [THR_WIDTH-1:0] ping_thr_ff;
   logic                 advance;
   logic                 req_take;
   logic                 core_valid;
   rsp_type              core_res;
   logic                 core_stopped;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance ? core_valid : (out_valid_ff && rsp_stall);

   mrd_core #(
      .TOPIC_LIMIT(TOPIC_LIMIT)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .item         (in_data_ff),
      .payload_limit(limit_ff),
      .ping_thr     (ping_thr_ff),
      .res_valid    (core_valid),
      .res          (core_res),
      .stopped      (core_stopped)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= PAYLOAD_LIMIT_RESET;
         ping_thr_ff  <= PING_THR_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_PAYLOAD_LIMIT: limit_ff <= csr_data;
               CSR_KEEPALIVE: ping_thr_ff <= THR_WIDTH'(csr_data[15:0])
                                             * THR_WIDTH'(PING_MS_PER_SECOND);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= core_res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef ASSERT_OFF
   a_stall_only_on_held_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !advance)
      else $error("held result overwritten");

   a_silent_when_stopped: assert property (@(posedge clock) disable iff (reset)
      (advance && core_stopped) |-> !core_valid)
      else $error("result after framing stop");

   a_stop_sticks: assert property (@(posedge clock) disable iff (reset)
      core_stopped |=> core_stopped)
      else $error("stop flag cleared without reset");
`endif

endmodule
